>>> hw/rtl/assert_macros.svh
// assertion macros shared by the utf-8 decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/utf8d_pkg.sv
// types and constants for the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned CntW  = 2;

  localparam logic [CntW-1:0] LenTwoByte   = 2'd1;
  localparam logic [CntW-1:0] LenThreeByte = 2'd2;
  localparam logic [CntW-1:0] LenFourByte  = 2'd3;

  localparam logic [1:0]  ContTag       = 2'b10;
  localparam logic [15:0] SurrogateMask = 16'hF800;
  localparam logic [15:0] SurrogateBase = 16'hD800;

  typedef struct packed {
    logic [CntW-1:0] bytes_left;
    logic [CntW-1:0] seq_length;
    logic [CpW-1:0]  partial_value;
    logic            string_failed;
  } state_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           error;
    logic           end_out;
  } result_t;

  localparam state_t StateIdle = '{default: '0};

endpackage

>>> hw/rtl/utf8d_byte_if.sv
// byte channel: one utf-8 byte and its end-of-string mark per request
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_in;

  modport source (output valid, output byte_in, output end_in, input ready);
  modport sink (input valid, input byte_in, input end_in, output ready);
endinterface

>>> hw/rtl/utf8d_cp_if.sv
// code point channel: one decoded character or an end-of-string status per request
interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        error;
  logic        end_out;

  modport source (output valid, output code_point, output error, output end_out,
                  input ready);
  modport sink (input valid, input code_point, input error, input end_out,
                output ready);
endinterface

>>> hw/rtl/utf8d_decode.sv
// combinational decode of one byte against the sequence state
module utf8d_decode (
  input  utf8d_pkg::state_t  state,
  input  logic [7:0]         byte_in,
  input  logic               end_in,
  output utf8d_pkg::state_t  state_next,
  output logic               res_valid,
  output utf8d_pkg::result_t res
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  shifted;
  logic [CntW-1:0] left_dec;
  logic            failing;
  logic            opened;

  assign shifted  = {state.partial_value[CpW-7:0], byte_in[5:0]};
  assign left_dec = state.bytes_left - 2'd1;

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '{default: '0};
    failing    = 1'b0;
    opened     = 1'b0;

    if (state.string_failed) begin
      if (end_in) begin
        state_next = StateIdle;
        res_valid  = 1'b1;
        res.error  = 1'b1;
        res.end_out = 1'b1;
      end
    end else if (state.bytes_left == '0) begin
      if (!byte_in[7]) begin
        state_next     = StateIdle;
        res_valid      = 1'b1;
        res.code_point = {{(CpW-ByteW){1'b0}}, byte_in};
        res.end_out    = end_in;
      end else if (!byte_in[6]) begin
        failing = 1'b1;
      end else if (!byte_in[5]) begin
        opened                   = 1'b1;
        state_next.seq_length    = LenTwoByte;
        state_next.partial_value = {{(CpW-5){1'b0}}, byte_in[4:0]};
      end else if (!byte_in[4]) begin
        opened                   = 1'b1;
        state_next.seq_length    = LenThreeByte;
        state_next.partial_value = {{(CpW-4){1'b0}}, byte_in[3:0]};
      end else if (!byte_in[3]) begin
        opened                   = 1'b1;
        state_next.seq_length    = LenFourByte;
        state_next.partial_value = {{(CpW-3){1'b0}}, byte_in[2:0]};
      end else begin
        failing = 1'b1;
      end
      if (opened) begin
        state_next.bytes_left = state_next.seq_length;
        if (end_in) failing = 1'b1;
      end
    end else if (byte_in[7:6] != ContTag) begin
      failing = 1'b1;
    end else begin
      state_next.partial_value = shifted;
      state_next.bytes_left    = left_dec;
      if (left_dec != '0) begin
        // truncated by end of string
        if (end_in) failing = 1'b1;
      end else if (state.seq_length == LenThreeByte &&
                   (shifted[15:0] & SurrogateMask) == SurrogateBase) begin
        failing = 1'b1;
      end else begin
        state_next     = StateIdle;
        res_valid      = 1'b1;
        res.code_point = shifted;
        res.end_out    = end_in;
      end
    end

    if (failing) begin
      state_next = StateIdle;
      if (end_in) begin
        res_valid      = 1'b1;
        res.code_point = '0;
        res.error      = 1'b1;
        res.end_out    = 1'b1;
      end else begin
        state_next.string_failed = 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/utf8d_outbuf.sv
// result register with a skid entry so one more result is taken while the output stalls
module utf8d_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utf8d_pkg::result_t push_data,
  output logic               can_push,
  utf8d_cp_if.source         out_ch
);
  import utf8d_pkg::*;

  logic    main_valid;
  logic    main_valid_next;
  result_t main;
  result_t main_next;
  logic    skid_valid;
  logic    skid_valid_next;
  result_t skid;
  result_t skid_next;

  always_comb begin
    main_valid_next = main_valid;
    main_next       = main;
    skid_valid_next = skid_valid;
    skid_next       = skid;
    if (!main_valid || out_ch.ready) begin
      if (skid_valid) begin
        main_valid_next = 1'b1;
        main_next       = skid;
        skid_valid_next = 1'b0;
      end else begin
        main_valid_next = push;
        main_next       = push_data;
      end
    end else if (push) begin
      skid_valid_next = 1'b1;
      skid_next       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
    main <= main_next;
    skid <= skid_next;
  end

  assign can_push          = !skid_valid;
  assign out_ch.valid      = main_valid;
  assign out_ch.code_point = main.code_point;
  assign out_ch.error      = main.error;
  assign out_ch.end_out    = main.end_out;

`include "assert_macros.svh"

  `U8D_ASSERT_NOW(a_skid_behind_main, skid_valid, main_valid, "skid entry without main entry")
  `U8D_ASSERT_NOW(a_no_push_when_full, push, !skid_valid, "result pushed into full buffer")

endmodule

>>> hw/rtl/utf8_stream_decoder.sv
// utf-8 byte stream to code point decoder, top level
//
//   channel      dir  payload                          request
//   byte_stream  in   byte_in[7:0], end_in             one string byte
//   cp_stream    out  code_point[20:0], error, end_out one character or string status
//
// one byte per clock while ready is high; a result appears on cp_stream the cycle after its byte unless stalled
// the sequence state register and the combinational decode logic close a feedback loop
// byte_stream.ready drops only while both result entries are held by a stall
// rst (synchronous) clears the sequence state and empties the result buffer
module utf8_stream_decoder (
  input logic          clk,
  input logic          rst,
  utf8d_byte_if.sink   byte_stream,
  utf8d_cp_if.source   cp_stream
);
  import utf8d_pkg::*;

  state_t  state;
  state_t  state_next;
  logic    res_valid;
  result_t res;
  logic    can_push;
  logic    accept;

  assign byte_stream.ready = can_push;
  assign accept            = byte_stream.valid && can_push;

  utf8d_decode u_decode (
    .state      (state),
    .byte_in    (byte_stream.byte_in),
    .end_in     (byte_stream.end_in),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateIdle;
    end else if (accept) begin
      state <= state_next;
    end
  end

  utf8d_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_ch    (cp_stream)
  );

`include "assert_macros.svh"

  `U8D_ASSERT_NOW(a_failed_no_seq, state.string_failed, state.bytes_left == '0 && state.seq_length == '0, "failed string still holds a sequence")
  `U8D_ASSERT_NOW(a_left_within_len, state.bytes_left != '0, state.seq_length != '0 && state.bytes_left <= state.seq_length, "continuation count exceeds sequence length")
  `U8D_ASSERT_NEXT(a_end_clears, accept && byte_stream.end_in, state == StateIdle, "state not cleared after end of string")
  `U8D_ASSERT_NOW(a_error_form, cp_stream.valid && cp_stream.error, cp_stream.code_point == '0 && cp_stream.end_out, "error result not a zero final result")

endmodule
